// ===== rtl/core/comb_allpass_room_reverb_top_macros.svh =====
// Assertion macros used by the port checker of the reverb block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef COMB_ALLPASS_ROOM_REVERB_TOP_MACROS_SVH
`define COMB_ALLPASS_ROOM_REVERB_TOP_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define CRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define CRR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/crr_pkg.sv =====
// Package of the comb/allpass room reverb: widths, fixed-point constants,
// register codes, configuration struct and sequencer states. No dependencies.
package crr_pkg;

  localparam int MAX_DELAY_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int NUM_COMBS  = 4;
  localparam int NUM_APS    = 2;
  localparam int COMB_IDX_W = 2;
  localparam int AP_IDX_W   = 1;

  localparam int COMB_W    = 18;
  localparam int AP_W      = 24;
  localparam int SUM_W     = COMB_W + 2;
  localparam int WET_W     = AP_W + 2;
  localparam int LEVEL_W   = 8;
  localparam int DELAY_W   = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [15:0] IN_GAIN  = 16'sd9830;
  localparam logic signed [15:0] COMB_FB  = 16'sd26214;
  localparam logic [15:0]        DRY_BASE = 16'd32113;
  localparam logic [LEVEL_W-1:0] WET_MAX  = 8'd128;

  localparam logic [LEVEL_W-1:0] WET_LEVEL_RST = 8'd20;
  localparam logic [NUM_COMBS-1:0][DELAY_W-1:0] COMB_DELAY_RST =
    {13'd1356, 13'd1277, 13'd1188, 13'd1116};
  localparam logic [NUM_APS-1:0][DELAY_W-1:0] AP_DELAY_RST = {13'd441, 13'd556};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WET_LEVEL,
    REG_COMB_DELAY_A,
    REG_COMB_DELAY_B,
    REG_COMB_DELAY_C,
    REG_COMB_DELAY_D,
    REG_ALLPASS_DELAY_A,
    REG_ALLPASS_DELAY_B
  } crr_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]                   wet_level;
    logic [NUM_COMBS-1:0][DELAY_W-1:0]    comb_delay;
    logic [NUM_APS-1:0][DELAY_W-1:0]      ap_delay;
  } crr_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_COMB_RD,
    ST_COMB_CALC,
    ST_COMB_WR,
    ST_AP_RD,
    ST_AP_CALC,
    ST_MIX
  } crr_state_e;

endpackage

// ===== rtl/core/crr_if.sv =====
// Channel interfaces of the reverb: input samples, output samples and
// register writes. Depends on crr_pkg.
interface crr_sample_if #(parameter int SAMPLE_BITS = crr_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          first_of_clip;

  modport source(output valid, sample_in, first_of_clip, input ready);
  modport sink(input valid, sample_in, first_of_clip, output ready);
endinterface

interface crr_result_if #(parameter int SAMPLE_BITS = crr_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

interface crr_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [crr_pkg::CFG_IDX_W-1:0]  index;
  logic [crr_pkg::DELAY_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/crr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module crr_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/crr_cfg.sv =====
// Register file of the reverb: mix level and delay lengths.
// Depends on crr_pkg and crr_cfg_if.
module crr_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  crr_cfg_if.sink           cfg_i,
  output crr_pkg::crr_cfg_t regs_o
);

  crr_pkg::crr_cfg_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (crr_pkg::crr_reg_e'(cfg_i.index))
        crr_pkg::REG_WET_LEVEL:       regs_d.wet_level     = cfg_i.data[crr_pkg::LEVEL_W-1:0];
        crr_pkg::REG_COMB_DELAY_A:    regs_d.comb_delay[0] = cfg_i.data;
        crr_pkg::REG_COMB_DELAY_B:    regs_d.comb_delay[1] = cfg_i.data;
        crr_pkg::REG_COMB_DELAY_C:    regs_d.comb_delay[2] = cfg_i.data;
        crr_pkg::REG_COMB_DELAY_D:    regs_d.comb_delay[3] = cfg_i.data;
        crr_pkg::REG_ALLPASS_DELAY_A: regs_d.ap_delay[0]   = cfg_i.data;
        crr_pkg::REG_ALLPASS_DELAY_B: regs_d.ap_delay[1]   = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.wet_level  <= crr_pkg::WET_LEVEL_RST;
      regs_q.comb_delay <= crr_pkg::COMB_DELAY_RST;
      regs_q.ap_delay   <= crr_pkg::AP_DELAY_RST;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

// ===== rtl/core/crr_core.sv =====
// Sequencer and datapath of the reverb: walks the four combs and two allpasses
// through their delay-line RAMs and mixes the result. Depends on crr_pkg, crr_if.
module crr_core #(
  parameter int MAX_DELAY   = crr_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = crr_pkg::SAMPLE_BITS_DEF,
  localparam int PosW       = $clog2(MAX_DELAY),
  localparam int CombAw     = PosW + crr_pkg::COMB_IDX_W,
  localparam int ApAw       = PosW + crr_pkg::AP_IDX_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  crr_pkg::crr_cfg_t         regs_i,
  crr_sample_if.sink                sample_i,
  crr_result_if.source              result_o,
  output logic                      comb_we_o,
  output logic [CombAw-1:0]         comb_waddr_o,
  output logic [crr_pkg::COMB_W-1:0] comb_wdata_o,
  output logic [CombAw-1:0]         comb_raddr_o,
  input  logic [crr_pkg::COMB_W-1:0] comb_rdata_i,
  output logic                      ap_we_o,
  output logic [ApAw-1:0]           ap_waddr_o,
  output logic [crr_pkg::AP_W-1:0]  ap_wdata_o,
  output logic [ApAw-1:0]           ap_raddr_o,
  input  logic [crr_pkg::AP_W-1:0]  ap_rdata_i
);

  localparam int FillW  = $clog2(MAX_DELAY + 1);
  localparam int CombW  = crr_pkg::COMB_W;
  localparam int ApW    = crr_pkg::AP_W;
  localparam int SumW   = crr_pkg::SUM_W;
  localparam int WetW   = crr_pkg::WET_W;
  localparam int MixAW  = SAMPLE_BITS + 17;
  localparam int MixBW  = WetW + 16;
  localparam int MixW   = ((MixAW > MixBW) ? MixAW : MixBW) + 1;
  localparam logic [crr_pkg::COMB_IDX_W-1:0] LastComb = crr_pkg::COMB_IDX_W'(crr_pkg::NUM_COMBS - 1);
  localparam logic [crr_pkg::AP_IDX_W-1:0]   LastAp   = crr_pkg::AP_IDX_W'(crr_pkg::NUM_APS - 1);
  localparam logic signed [31:0] CombHi = (32'sd1 <<< (CombW - 1)) - 32'sd1;
  localparam logic signed [31:0] CombLo = ~CombHi;
  localparam logic signed [31:0] ApHi   = (32'sd1 <<< (ApW - 1)) - 32'sd1;
  localparam logic signed [31:0] ApLo   = ~ApHi;
  localparam logic signed [MixW-1:0] OutHi = MixW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [MixW-1:0] OutLo = ~OutHi;

  function automatic logic [FillW-1:0] eff_len(input logic [crr_pkg::DELAY_W-1:0] r);
    if (r == '0) return FillW'(1);
    if (32'(r) > 32'(MAX_DELAY)) return FillW'(MAX_DELAY);
    return FillW'(r);
  endfunction

  crr_pkg::crr_state_e state_q, state_d;

  logic [crr_pkg::COMB_IDX_W-1:0] k_q, k_d;
  logic [crr_pkg::AP_IDX_W-1:0]   j_q, j_d;
  logic [PosW-1:0]          comb_pos_q  [crr_pkg::NUM_COMBS];
  logic [PosW-1:0]          comb_pos_d  [crr_pkg::NUM_COMBS];
  logic [FillW-1:0]         comb_fill_q [crr_pkg::NUM_COMBS];
  logic [FillW-1:0]         comb_fill_d [crr_pkg::NUM_COMBS];
  logic signed [CombW-1:0]  damp_q      [crr_pkg::NUM_COMBS];
  logic signed [CombW-1:0]  damp_d      [crr_pkg::NUM_COMBS];
  logic [PosW-1:0]          ap_pos_q    [crr_pkg::NUM_APS];
  logic [PosW-1:0]          ap_pos_d    [crr_pkg::NUM_APS];
  logic [FillW-1:0]         ap_fill_q   [crr_pkg::NUM_APS];
  logic [FillW-1:0]         ap_fill_d   [crr_pkg::NUM_APS];
  logic                     out_valid_q, out_valid_d;

  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic signed [SAMPLE_BITS-1:0] feed_q, feed_d;
  logic signed [SumW-1:0]        sum_q, sum_d;
  logic signed [WetW-1:0]        wet_q, wet_d;
  logic signed [SAMPLE_BITS-1:0] sample_out_q, sample_out_d;

  logic                           in_acc;
  logic                           mix_load;
  logic                           wet_off;
  logic signed [SAMPLE_BITS+15:0] feed_prod;
  logic signed [SAMPLE_BITS+15:0] feed_rnd;
  logic [PosW-1:0]                comb_pos;
  logic [FillW-1:0]               comb_fill;
  logic [FillW-1:0]               comb_next;
  logic [FillW-1:0]               comb_len;
  logic signed [CombW-1:0]        comb_out;
  logic signed [CombW:0]          damp_sum;
  logic signed [CombW+15:0]       fb_prod;
  logic signed [CombW+15:0]       fb_rnd;
  logic signed [31:0]             comb_acc;
  logic [PosW-1:0]                ap_pos;
  logic [FillW-1:0]               ap_fill;
  logic [FillW-1:0]               ap_next;
  logic [FillW-1:0]               ap_len;
  logic signed [ApW-1:0]          ap_bo;
  logic signed [ApW:0]            ap_bo_rnd;
  logic signed [WetW-1:0]         ap_in;
  logic signed [31:0]             ap_acc;
  logic [crr_pkg::LEVEL_W-1:0]    wl;
  logic [14:0]                    wl_scaled;
  logic [15:0]                    dry;
  logic signed [MixAW-1:0]        mix_a;
  logic signed [MixBW-1:0]        mix_b;
  logic signed [MixW-1:0]         mix_sum;
  logic signed [MixW-1:0]         mix_rs;
  logic signed [SAMPLE_BITS-1:0]  mix_sat;

  assign in_acc   = sample_i.valid && sample_i.ready;
  assign mix_load = (state_q == crr_pkg::ST_MIX) && (!out_valid_q || result_o.ready);
  assign wet_off  = (regs_i.wet_level == '0);

  // Comb arithmetic.
  assign comb_pos  = comb_pos_q[k_q];
  assign comb_fill = comb_fill_q[k_q];
  assign comb_next = FillW'(comb_pos) + FillW'(1);
  assign comb_len  = eff_len(regs_i.comb_delay[k_q]);
  assign comb_out  = (FillW'(comb_pos) < comb_fill) ? $signed(comb_rdata_i) : '0;
  assign damp_sum  = (CombW+1)'(comb_out) + (CombW+1)'(damp_q[k_q]) + (CombW+1)'(1);
  assign fb_prod   = damp_q[k_q] * crr_pkg::COMB_FB;
  assign fb_rnd    = (fb_prod + (CombW+16)'(16384)) >>> 15;
  assign comb_acc  = 32'(feed_q) + 32'(fb_rnd);

  assign feed_prod = x_q * crr_pkg::IN_GAIN;
  assign feed_rnd  = (feed_prod + (SAMPLE_BITS+16)'(16384)) >>> 15;

  // Allpass arithmetic.
  assign ap_pos    = ap_pos_q[j_q];
  assign ap_fill   = ap_fill_q[j_q];
  assign ap_next   = FillW'(ap_pos) + FillW'(1);
  assign ap_len    = eff_len(regs_i.ap_delay[j_q]);
  assign ap_bo     = (FillW'(ap_pos) < ap_fill) ? $signed(ap_rdata_i) : '0;
  assign ap_bo_rnd = ((ApW+1)'(ap_bo) + (ApW+1)'(1)) >>> 1;
  assign ap_in     = (j_q == '0) ? WetW'(sum_q) : wet_q;
  assign ap_acc    = 32'(ap_in) + 32'(ap_bo_rnd);

  // Output mix.
  assign wl        = (regs_i.wet_level > crr_pkg::WET_MAX) ? crr_pkg::WET_MAX : regs_i.wet_level;
  assign wl_scaled = {wl, 7'b0};
  assign dry       = crr_pkg::DRY_BASE - {1'b0, wl_scaled};
  assign mix_a     = x_q * $signed({1'b0, dry});
  assign mix_b     = wet_q * $signed({1'b0, wl_scaled});
  assign mix_sum   = MixW'(mix_a) + MixW'(mix_b) + MixW'(16384);
  assign mix_rs    = mix_sum >>> 15;
  assign mix_sat   = (mix_rs > OutHi) ? OutHi[SAMPLE_BITS-1:0] :
                     (mix_rs < OutLo) ? OutLo[SAMPLE_BITS-1:0] : mix_rs[SAMPLE_BITS-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crr_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = wet_off ? crr_pkg::ST_MIX : crr_pkg::ST_FEED;
        end
      end
      crr_pkg::ST_FEED:      state_d = crr_pkg::ST_COMB_CALC;
      crr_pkg::ST_COMB_RD:   state_d = crr_pkg::ST_COMB_CALC;
      crr_pkg::ST_COMB_CALC: state_d = crr_pkg::ST_COMB_WR;
      crr_pkg::ST_COMB_WR: begin
        state_d = (k_q == LastComb) ? crr_pkg::ST_AP_CALC : crr_pkg::ST_COMB_RD;
      end
      crr_pkg::ST_AP_RD:     state_d = crr_pkg::ST_AP_CALC;
      crr_pkg::ST_AP_CALC: begin
        state_d = (j_q == LastAp) ? crr_pkg::ST_MIX : crr_pkg::ST_AP_RD;
      end
      crr_pkg::ST_MIX: begin
        if (mix_load) begin
          state_d = crr_pkg::ST_IDLE;
        end
      end
      default: state_d = crr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready = (state_q == crr_pkg::ST_IDLE);
    comb_raddr_o   = {k_q, comb_pos};
    comb_waddr_o   = {k_q, comb_pos};
    comb_we_o      = (state_q == crr_pkg::ST_COMB_WR);
    comb_wdata_o   = (comb_acc > CombHi) ? CombHi[CombW-1:0] :
                     (comb_acc < CombLo) ? CombLo[CombW-1:0] : comb_acc[CombW-1:0];
    ap_raddr_o     = {j_q, ap_pos};
    ap_waddr_o     = {j_q, ap_pos};
    ap_we_o        = (state_q == crr_pkg::ST_AP_CALC);
    ap_wdata_o     = (ap_acc > ApHi) ? ApHi[ApW-1:0] :
                     (ap_acc < ApLo) ? ApLo[ApW-1:0] : ap_acc[ApW-1:0];
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.sample_out = sample_out_q;

  always_comb begin
    k_d          = k_q;
    j_d          = j_q;
    comb_pos_d   = comb_pos_q;
    comb_fill_d  = comb_fill_q;
    damp_d       = damp_q;
    ap_pos_d     = ap_pos_q;
    ap_fill_d    = ap_fill_q;
    x_d          = x_q;
    feed_d       = feed_q;
    sum_d        = sum_q;
    wet_d        = wet_q;
    sample_out_d = sample_out_q;
    out_valid_d  = out_valid_q && !result_o.ready;

    unique case (state_q)
      crr_pkg::ST_IDLE: begin
        if (in_acc) begin
          x_d   = sample_i.sample_in;
          k_d   = '0;
          j_d   = '0;
          sum_d = '0;
          if (sample_i.first_of_clip) begin
            for (int i = 0; i < crr_pkg::NUM_COMBS; i++) begin
              comb_pos_d[i]  = '0;
              comb_fill_d[i] = '0;
              damp_d[i]      = '0;
            end
            for (int i = 0; i < crr_pkg::NUM_APS; i++) begin
              ap_pos_d[i]  = '0;
              ap_fill_d[i] = '0;
            end
          end
        end
      end
      crr_pkg::ST_FEED: begin
        feed_d = feed_rnd[SAMPLE_BITS-1:0];
      end
      crr_pkg::ST_COMB_CALC: begin
        damp_d[k_q] = damp_sum[CombW:1];
        sum_d       = sum_q + SumW'(comb_out);
      end
      crr_pkg::ST_COMB_WR: begin
        comb_pos_d[k_q] = (comb_next >= comb_len) ? '0 : comb_next[PosW-1:0];
        if (FillW'(comb_pos) == comb_fill) begin
          comb_fill_d[k_q] = comb_fill + FillW'(1);
        end
        if (k_q != LastComb) begin
          k_d = k_q + 1'b1;
        end
      end
      crr_pkg::ST_AP_CALC: begin
        wet_d         = WetW'(ap_bo) - ap_in;
        ap_pos_d[j_q] = (ap_next >= ap_len) ? '0 : ap_next[PosW-1:0];
        if (FillW'(ap_pos) == ap_fill) begin
          ap_fill_d[j_q] = ap_fill + FillW'(1);
        end
        if (j_q != LastAp) begin
          j_d = j_q + 1'b1;
        end
      end
      crr_pkg::ST_MIX: begin
        if (mix_load) begin
          sample_out_d = wet_off ? x_q : mix_sat;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crr_pkg::ST_IDLE;
      k_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < crr_pkg::NUM_COMBS; i++) begin
        comb_pos_q[i]  <= '0;
        comb_fill_q[i] <= '0;
        damp_q[i]      <= '0;
      end
      for (int i = 0; i < crr_pkg::NUM_APS; i++) begin
        ap_pos_q[i]  <= '0;
        ap_fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      comb_pos_q  <= comb_pos_d;
      comb_fill_q <= comb_fill_d;
      damp_q      <= damp_d;
      ap_pos_q    <= ap_pos_d;
      ap_fill_q   <= ap_fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    feed_q       <= feed_d;
    sum_q        <= sum_d;
    wet_q        <= wet_d;
    sample_out_q <= sample_out_d;
  end

endmodule

// ===== rtl/core/comb_allpass_room_reverb_top.sv =====
// Top level of the comb/allpass room reverb. Depends on crr_pkg, crr_if,
// crr_cfg, crr_core and crr_ram.
//
// Samples enter on sample_i (valid/ready); a word is taken when both are high.
// Each mixed sample leaves on result_o from an output register, one word per
// input word, in order. Register writes arrive on cfg_i, which is always ready;
// the user must make them only while the block is idle, as the block itself
// does not enforce it. With a nonzero wet level the sequencer reads and writes
// the four comb lines one after another in a shared RAM, then the two allpass
// lines in a second RAM, then mixes. With wet level zero the sample is passed
// through unchanged. A new sample is taken only once the previous one has been
// loaded into the output register.
// Reset loads the register defaults and empties all delay lines at once: each
// line keeps a fill count, and entries at or beyond it read as zero, so no
// clearing pass is run. A first-of-clip word does the same before it is used.
// When the receiver stalls, the output word is held and the next sample is
// still accepted and processed up to the mix, where it waits.
module comb_allpass_room_reverb_top #(
  parameter int MAX_DELAY   = crr_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = crr_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  crr_sample_if.sink    sample_i,
  crr_result_if.source  result_o,
  crr_cfg_if.sink       cfg_i
);

  localparam int PosW      = $clog2(MAX_DELAY);
  localparam int CombAw    = PosW + crr_pkg::COMB_IDX_W;
  localparam int ApAw      = PosW + crr_pkg::AP_IDX_W;
  localparam int CombDepth = crr_pkg::NUM_COMBS * (2 ** PosW);
  localparam int ApDepth   = crr_pkg::NUM_APS * (2 ** PosW);

  crr_pkg::crr_cfg_t          regs;
  logic                       comb_we;
  logic [CombAw-1:0]          comb_waddr;
  logic [crr_pkg::COMB_W-1:0] comb_wdata;
  logic [CombAw-1:0]          comb_raddr;
  logic [crr_pkg::COMB_W-1:0] comb_rdata;
  logic                       ap_we;
  logic [ApAw-1:0]            ap_waddr;
  logic [crr_pkg::AP_W-1:0]   ap_wdata;
  logic [ApAw-1:0]            ap_raddr;
  logic [crr_pkg::AP_W-1:0]   ap_rdata;

  crr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  crr_core #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .regs_i       (regs),
    .sample_i     (sample_i),
    .result_o     (result_o),
    .comb_we_o    (comb_we),
    .comb_waddr_o (comb_waddr),
    .comb_wdata_o (comb_wdata),
    .comb_raddr_o (comb_raddr),
    .comb_rdata_i (comb_rdata),
    .ap_we_o      (ap_we),
    .ap_waddr_o   (ap_waddr),
    .ap_wdata_o   (ap_wdata),
    .ap_raddr_o   (ap_raddr),
    .ap_rdata_i   (ap_rdata)
  );

  crr_ram #(
    .WIDTH (crr_pkg::COMB_W),
    .DEPTH (CombDepth)
  ) u_comb_ram (
    .clk_i   (clk_i),
    .we_i    (comb_we),
    .waddr_i (comb_waddr),
    .wdata_i (comb_wdata),
    .raddr_i (comb_raddr),
    .rdata_o (comb_rdata)
  );

  crr_ram #(
    .WIDTH (crr_pkg::AP_W),
    .DEPTH (ApDepth)
  ) u_ap_ram (
    .clk_i   (clk_i),
    .we_i    (ap_we),
    .waddr_i (ap_waddr),
    .wdata_i (ap_wdata),
    .raddr_i (ap_raddr),
    .rdata_o (ap_rdata)
  );

endmodule

// ===== rtl/core/crr_checker.sv =====
// Port-level checker of the reverb top level, attached by bind.
// Depends on crr_pkg and comb_allpass_room_reverb_top_macros.svh.
`include "comb_allpass_room_reverb_top_macros.svh"

module crr_port_checker #(
  parameter int SAMPLE_BITS = crr_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] sample_out_i
);

  logic [1:0] pend_q, pend_d;

  // Number of accepted words whose output word has not yet been taken.
  always_comb begin
    pend_d = pend_q + 2'(in_valid_i && in_ready_i) - 2'(out_valid_i && out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `CRR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output word dropped")
  `CRR_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(sample_out_i), "output word changed")
  `CRR_ASSERT_NEVER(a_no_extra, out_valid_i && pend_q == 2'd0, "output word without input word")
  `CRR_ASSERT_NEVER(a_idle_depth, in_ready_i && pend_q == 2'd2, "ready with two words pending")

endmodule

bind comb_allpass_room_reverb_top crr_port_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_crr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .sample_out_i (result_o.sample_out)
);

// ===== tb/crr_checker.sv =====
// Scoreboard of the comb/allpass room reverb: watches the sample, result and
// register channels, predicts every output word and compares it.
// Depends on crr_pkg and the channel interfaces in crr_if.
`timescale 1ns / 100ps

module crr_checker #(
  parameter int MAX_DELAY   = crr_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = crr_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crr_sample_if       sample_mon,
  crr_result_if       result_mon,
  crr_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_count_o
);
  import crr_pkg::*;

  localparam longint IN_GAIN_Q = 9830;
  localparam longint COMB_FB_Q = 26214;
  localparam longint DRY_Q     = 32768 - 655;
  localparam int     REPORT_MAX = 10;

  crr_cfg_t                      live_cfg;
  logic signed [COMB_W-1:0]      comb_line [NUM_COMBS][MAX_DELAY];
  logic signed [COMB_W-1:0]      damp_store [NUM_COMBS];
  int unsigned                   comb_pos [NUM_COMBS];
  logic signed [AP_W-1:0]        ap_line [NUM_APS][MAX_DELAY];
  int unsigned                   ap_pos [NUM_APS];
  logic signed [SAMPLE_BITS-1:0] predicted_mix_q [$];
  int unsigned                   words_checked;

  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic int unsigned next_pos(input int unsigned p, input logic [DELAY_W-1:0] r);
    int unsigned len;
    int unsigned q;
    len = (r == 0) ? 1 : ((r > MAX_DELAY) ? MAX_DELAY : int'(r));
    q = p + 1;
    return (q >= len || q >= MAX_DELAY) ? 0 : q;
  endfunction

  function automatic void clear_lines();
    int k;
    int p;
    for (k = 0; k < NUM_COMBS; k++) begin
      for (p = 0; p < MAX_DELAY; p++) comb_line[k][p] = '0;
      damp_store[k] = '0;
      comb_pos[k] = 0;
    end
    for (k = 0; k < NUM_APS; k++) begin
      for (p = 0; p < MAX_DELAY; p++) ap_line[k][p] = '0;
      ap_pos[k] = 0;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] room_reverb_mix(input longint x,
                                                                    input logic clip);
    longint wl;
    longint feed;
    longint wet;
    longint tap;
    longint st;
    longint mix;
    int unsigned p;
    int k;
    if (clip) clear_lines();
    wl = (live_cfg.wet_level > 8'd128) ? 128 : longint'(live_cfg.wet_level);
    if (wl == 0) return SAMPLE_BITS'(x);
    feed = round_q(x * IN_GAIN_Q, 15);
    wet = 0;
    for (k = 0; k < NUM_COMBS; k++) begin
      p = comb_pos[k];
      tap = comb_line[k][p];
      st = clamp(round_q(tap + damp_store[k], 1), COMB_W);
      damp_store[k] = COMB_W'(st);
      comb_line[k][p] = COMB_W'(clamp(feed + round_q(st * COMB_FB_Q, 15), COMB_W));
      comb_pos[k] = next_pos(p, live_cfg.comb_delay[k]);
      wet += tap;
    end
    for (k = 0; k < NUM_APS; k++) begin
      p = ap_pos[k];
      tap = ap_line[k][p];
      ap_line[k][p] = AP_W'(clamp(wet + round_q(tap, 1), AP_W));
      ap_pos[k] = next_pos(p, live_cfg.ap_delay[k]);
      wet = tap - wet;
    end
    mix = clamp(round_q(x * (DRY_Q - wl * 128) + wet * wl * 128, 15), SAMPLE_BITS);
    return SAMPLE_BITS'(mix);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      live_cfg.wet_level  = WET_LEVEL_RST;
      live_cfg.comb_delay = COMB_DELAY_RST;
      live_cfg.ap_delay   = AP_DELAY_RST;
      clear_lines();
      predicted_mix_q.delete();
      fail_count_o  = 0;
      words_checked = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_WET_LEVEL: live_cfg.wet_level = cfg_mon.data[LEVEL_W-1:0];
          REG_COMB_DELAY_A, REG_COMB_DELAY_B, REG_COMB_DELAY_C, REG_COMB_DELAY_D: begin
            live_cfg.comb_delay[cfg_mon.index - REG_COMB_DELAY_A] = cfg_mon.data;
          end
          REG_ALLPASS_DELAY_A, REG_ALLPASS_DELAY_B: begin
            live_cfg.ap_delay[cfg_mon.index - REG_ALLPASS_DELAY_A] = cfg_mon.data;
          end
          default: ;
        endcase
      end
      if (sample_mon.valid && sample_mon.ready) begin
        predicted_mix_q.push_back(room_reverb_mix(sample_mon.sample_in,
                                                  sample_mon.first_of_clip));
      end
      if (result_mon.valid && result_mon.ready) begin
        if (predicted_mix_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX) begin
            $display("output word %0d: no input word waiting for it, got %0d",
                     words_checked, result_mon.sample_out);
          end
          fail_count_o++;
        end else begin
          want = predicted_mix_q.pop_front();
          if (result_mon.sample_out !== want) begin
            if (fail_count_o < REPORT_MAX) begin
              $display("output word %0d: sample_out expected %0d, got %0d",
                       words_checked, want, result_mon.sample_out);
            end
            fail_count_o++;
          end
        end
        words_checked++;
      end
    end
    pending_count_o = predicted_mix_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the reverb testbench: clock, reset, sample and register stimulus,
// ready stalls and the verdict. Depends on crr_pkg, crr_if, the block and crr_checker.
`timescale 1ns / 100ps

module testbench;
  import crr_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1730;
  localparam int PHASES       = 10;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int {WAVE_NOISE, WAVE_HOLD, WAVE_SQUARE, WAVE_QUIET, WAVE_IMPULSE} wave_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          steady_tail = 1'b0;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  int unsigned samples_sent;
  int unsigned clips_opened;
  int unsigned settings_made;
  int unsigned reg_writes;

  crr_sample_if sample_ch ();
  crr_result_if result_ch ();
  crr_cfg_if    cfg_ch ();

  comb_allpass_room_reverb_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  crr_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_mon      (sample_ch),
    .result_mon      (result_ch),
    .cfg_mon         (cfg_ch),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] smp, input logic clip);
    int gap;
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    sample_ch.valid         <= 1'b1;
    sample_ch.sample_in     <= smp;
    sample_ch.first_of_clip <= clip;
    do @(posedge clk_i); while (!sample_ch.ready);
    samples_sent++;
    if (clip) clips_opened++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
  endtask

  // Stops the sample stream and waits until every predicted word has come out.
  task automatic settle();
    @(negedge clk_i);
    sample_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2, 3:    return DELAY_W'(4096);
      4:       return DELAY_W'(8191);
      5:       return DELAY_W'($urandom_range(4097, 8191));
      6, 7:    return DELAY_W'($urandom_range(49, 4096));
      default: return DELAY_W'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] pick_wet();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DELAY_W'(128);
      2:       return DELAY_W'($urandom_range(129, 8191));
      default: return DELAY_W'($urandom_range(1, 127));
    endcase
  endfunction

  task automatic random_setting();
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, DELAY_W'($urandom));
    write_reg(REG_WET_LEVEL, pick_wet());
    write_reg(REG_COMB_DELAY_A, pick_delay());
    write_reg(REG_COMB_DELAY_B, pick_delay());
    write_reg(REG_COMB_DELAY_C, pick_delay());
    write_reg(REG_COMB_DELAY_D, pick_delay());
    write_reg(REG_ALLPASS_DELAY_A, pick_delay());
    write_reg(REG_ALLPASS_DELAY_B, pick_delay());
    settings_made++;
  endtask

  // One clip: an opening word that clears the state when fresh is set, then a waveform.
  task automatic play_clip(input int len, input bit fresh);
    wave_e                           wave;
    logic signed [SAMPLE_BITS_DEF-1:0] level;
    logic signed [SAMPLE_BITS_DEF-1:0] smp;
    logic                            clip;
    int                              period;
    int                              i;
    wave   = wave_e'($urandom_range(0, 4));
    level  = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
    period = $urandom_range(1, 20);
    for (i = 0; i < len; i++) begin
      case (wave)
        WAVE_NOISE:  smp = 16'($urandom);
        WAVE_HOLD:   smp = level;
        WAVE_SQUARE: smp = ((i / period) % 2 == 0) ? level : ~level;
        WAVE_QUIET:  smp = 16'(int'($urandom_range(0, 64)) - 32);
        default:     smp = (i == 0) ? level : '0;
      endcase
      clip = (i == 0) ? fresh : ($urandom_range(0, 39) == 0);
      send_sample(smp, clip);
    end
  endtask

  initial begin
    int phase;
    int budget;
    int len;
    bit fresh;
    int i;
    sample_ch.valid         = 1'b0;
    sample_ch.sample_in     = '0;
    sample_ch.first_of_clip = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    send_sample(16'sh7FFF, 1'b1);

    // With the wet level at zero a clearing word still passes unchanged.
    settle();
    write_reg(REG_WET_LEVEL, '0);
    settings_made++;
    send_sample(16'sh3039, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);

    // Wet level over one half, zero and overlong delays, and an unmapped index.
    settle();
    write_reg(REG_UNMAPPED, DELAY_W'(8191));
    write_reg(REG_WET_LEVEL, DELAY_W'(255));
    write_reg(REG_COMB_DELAY_A, '0);
    write_reg(REG_COMB_DELAY_B, DELAY_W'(1));
    write_reg(REG_COMB_DELAY_C, DELAY_W'(2));
    write_reg(REG_COMB_DELAY_D, DELAY_W'(3));
    write_reg(REG_ALLPASS_DELAY_A, DELAY_W'(8191));
    write_reg(REG_ALLPASS_DELAY_B, DELAY_W'(4097));
    settings_made++;
    for (i = 0; i < 6; i++) send_sample(16'sh7FFF, i == 0);
    for (i = 0; i < 3; i++) send_sample(16'sh8000, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == PHASES - 1) steady_tail = 1'b1;
      random_setting();
      budget = RANDOM_ITEMS / PHASES;
      // About half the phases carry the old clip on under new delay lengths.
      fresh = ($urandom_range(0, 1) == 0);
      while (budget > 0) begin
        len = $urandom_range(4, 60);
        if (len > budget) len = budget;
        play_clip(len, fresh);
        budget -= len;
        fresh = ($urandom_range(0, 9) != 0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d samples in %0d clips over %0d register settings (%0d writes),",
             samples_sent, clips_opened, settings_made, reg_writes);
    $display("with stalls on both channels in all but the last phase.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int hold;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!steady_tail && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 17);
        result_ch.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
        @(negedge clk_i);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d words outstanding.",
             cycle_count, pending_count);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== comb_allpass_room_reverb_top.f =====
+incdir+rtl/core
rtl/core/crr_pkg.sv
rtl/core/crr_if.sv
rtl/core/crr_ram.sv
rtl/core/crr_cfg.sv
rtl/core/crr_core.sv
rtl/core/comb_allpass_room_reverb_top.sv
rtl/core/crr_checker.sv
tb/crr_checker.sv
tb/testbench.sv
